// File: rtl/fthm_pkg.sv
// ----------------------------------------------------------------------------
// Frame time histogram monitor package
// Shared sizes, bucket edges, register and statistic codes, queue entry type.
// ----------------------------------------------------------------------------
package fthm_pkg;

    localparam int NUM_BUCKETS = 10;
    localparam int COUNT_WIDTH = 40;
    localparam int SUM_WIDTH   = 48;
    localparam int WIDE_WIDTH  = SUM_WIDTH + 1;
    localparam int SLOT_WIDTH  = $clog2(NUM_BUCKETS);
    localparam int EDGE_SLOTS  = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_DATA_W = 24;

    localparam logic [23:0] EDGE_US [EDGE_SLOTS] = '{
        24'd4000, 24'd8000, 24'd12000, 24'd16670, 24'd20000, 24'd25000,
        24'd33300, 24'd50000, 24'd100000, 24'd200000, 24'd400000,
        24'd800000, 24'd1600000, 24'd3200000, 24'd6400000
    };

    localparam logic [9:0] STEP_SCALE = 10'd1000;
    localparam logic [9:0] RAW_SCALE  = 10'd999;

    localparam logic [19:0] SPIKE_THRESHOLD_RESET = 20'd16700;
    localparam logic [23:0] VALID_LIMIT_RESET     = 24'd1000000;

    localparam logic [0:0] CFG_SPIKE_THRESHOLD = 1'b0;
    localparam logic [0:0] CFG_VALID_LIMIT     = 1'b1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // offsets above the bucket indexes
    localparam logic [4:0] STAT_FRAMES     = 5'd0;
    localparam logic [4:0] STAT_DILATED    = 5'd1;
    localparam logic [4:0] STAT_SPIKES     = 5'd2;
    localparam logic [4:0] STAT_MISSED     = 5'd3;
    localparam logic [4:0] STAT_REAL_SUM   = 5'd4;
    localparam logic [4:0] STAT_SIM_SUM    = 5'd5;
    localparam logic [4:0] STAT_WORST      = 5'd6;
    localparam logic [4:0] STAT_WORST_TIME = 5'd7;

    typedef struct packed {
        logic                  mode;
        logic [31:0]           frame_number;
        logic [23:0]           raw_us;
        logic [23:0]           step_us;
        logic [31:0]           elapsed_ms;
        logic [4:0]            stat_index;
        logic [SLOT_WIDTH-1:0] slot;
        logic                  valid;
        logic                  dilated;
        logic                  spike;
    } entry_t;

endpackage

// File: rtl/fthm_front.sv
// ----------------------------------------------------------------------------
// Front classifier
// Holds the configuration registers and tags each request with its bucket,
// validity, slow-motion and spike flags.
// ----------------------------------------------------------------------------
module fthm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [fthm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [fthm_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output fthm_pkg::entry_t                   entry
);

    logic [19:0] spike_threshold_reg;
    logic [23:0] valid_limit_reg;

    logic [23:0]                     raw;
    logic [23:0]                     step;
    logic [33:0]                     step_scaled;
    logic [33:0]                     raw_scaled;
    logic [fthm_pkg::SLOT_WIDTH-1:0] slot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spike_threshold_reg <= fthm_pkg::SPIKE_THRESHOLD_RESET;
            valid_limit_reg     <= fthm_pkg::VALID_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                fthm_pkg::CFG_SPIKE_THRESHOLD: spike_threshold_reg <= cfg_wdata[19:0];
                fthm_pkg::CFG_VALID_LIMIT:     valid_limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign raw  = s_tdata[55:32];
    assign step = s_tdata[79:56];

    assign step_scaled = {10'd0, step} * {24'd0, fthm_pkg::STEP_SCALE};
    assign raw_scaled  = {10'd0, raw} * {24'd0, fthm_pkg::RAW_SCALE};

    always_comb begin
        slot = fthm_pkg::SLOT_WIDTH'(fthm_pkg::NUM_BUCKETS - 1);
        for (int i = fthm_pkg::NUM_BUCKETS - 2; i >= 0; i--) begin
            if (raw < fthm_pkg::EDGE_US[i]) begin
                slot = fthm_pkg::SLOT_WIDTH'(i);
            end
        end
    end

    always_comb begin
        entry.mode         = s_tuser;
        entry.frame_number = s_tdata[31:0];
        entry.raw_us       = raw;
        entry.step_us      = step;
        entry.elapsed_ms   = s_tdata[111:80];
        entry.stat_index   = s_tdata[116:112];
        entry.slot         = slot;
        entry.valid        = (raw != 24'd0) && (raw < valid_limit_reg);
        entry.dilated      = step_scaled < raw_scaled;
        entry.spike        = raw > {4'd0, spike_threshold_reg};
    end

endmodule

// File: rtl/fthm_queue.sv
// ----------------------------------------------------------------------------
// Request queue
// Short in-order queue between the classifier and the statistics engine.
// ----------------------------------------------------------------------------
module fthm_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fthm_pkg::entry_t push_entry,
    input  logic             pop,
    output fthm_pkg::entry_t head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W   = $clog2(fthm_pkg::QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(fthm_pkg::QUEUE_DEPTH + 1);

    fthm_pkg::entry_t   slot_reg [fthm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fthm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fthm_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == COUNT_W'(fthm_pkg::QUEUE_DEPTH));

endmodule

// File: rtl/fthm_back.sv
// ----------------------------------------------------------------------------
// Statistics engine
// Applies frame samples to the saturating counters and answers reads
// through a registered result stage.
// ----------------------------------------------------------------------------
module fthm_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fthm_pkg::entry_t                   head,
    input  logic                               empty,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fthm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CW = fthm_pkg::COUNT_WIDTH;
    localparam int SW = fthm_pkg::SUM_WIDTH;
    localparam int WW = fthm_pkg::WIDE_WIDTH;
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [SW-1:0] SUM_MAX   = '1;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

    logic [31:0]   prev_frame_reg;
    logic [CW-1:0] bucket_reg [fthm_pkg::NUM_BUCKETS];
    logic [CW-1:0] frame_total_reg;
    logic [CW-1:0] dilated_total_reg;
    logic [CW-1:0] spike_total_reg;
    logic [CW-1:0] missed_total_reg;
    logic [SW-1:0] real_sum_reg;
    logic [SW-1:0] sim_sum_reg;
    logic [23:0]   worst_us_reg;
    logic [31:0]   worst_time_reg;
    logic          m_valid_reg;
    logic [SW-1:0] m_value_reg;
    logic [4:0]    m_which_reg;

    logic [CW-1:0] bucket_next [fthm_pkg::NUM_BUCKETS];
    logic [CW-1:0] frame_total_next;
    logic [CW-1:0] dilated_total_next;
    logic [CW-1:0] spike_total_next;
    logic [CW-1:0] missed_total_next;
    logic [SW-1:0] real_sum_next;
    logic [SW-1:0] sim_sum_next;
    logic [23:0]   worst_us_next;
    logic [31:0]   worst_time_next;
    logic [31:0]   prev_frame_next;
    logic          m_valid_next;

    logic          is_read;
    logic          sample_new;
    logic          take;
    logic [32:0]   gap;
    logic          gap_hit;
    logic [WW-1:0] missed_wide;
    logic [WW-1:0] real_wide;
    logic [WW-1:0] sim_wide;
    logic [4:0]    rel_index;
    logic [SW-1:0] rd_value;

    assign is_read = (head.mode == fthm_pkg::MODE_READ);
    assign pop     = !empty && (!is_read || !m_valid_reg || m_tready);

    assign sample_new = pop && !is_read && (head.frame_number != prev_frame_reg);
    assign take       = sample_new && head.valid;

    assign gap     = {1'b0, head.frame_number} - {1'b0, prev_frame_reg} - 33'd1;
    assign gap_hit = (prev_frame_reg != 32'd0) &&
                     ({1'b0, head.frame_number} > ({1'b0, prev_frame_reg} + 33'd1));

    assign missed_wide = WW'(missed_total_reg) + WW'(gap);
    assign real_wide   = WW'(real_sum_reg) + WW'(head.raw_us);
    assign sim_wide    = WW'(sim_sum_reg) + WW'(head.step_us);

    always_comb begin
        prev_frame_next    = prev_frame_reg;
        frame_total_next   = frame_total_reg;
        dilated_total_next = dilated_total_reg;
        spike_total_next   = spike_total_reg;
        missed_total_next  = missed_total_reg;
        real_sum_next      = real_sum_reg;
        sim_sum_next       = sim_sum_reg;
        worst_us_next      = worst_us_reg;
        worst_time_next    = worst_time_reg;
        for (int i = 0; i < fthm_pkg::NUM_BUCKETS; i++) begin
            bucket_next[i] = bucket_reg[i];
            if (take && head.slot == fthm_pkg::SLOT_WIDTH'(i)) begin
                bucket_next[i] = sat_inc(bucket_reg[i]);
            end
        end
        if (sample_new) begin
            prev_frame_next = head.frame_number;
            if (gap_hit) begin
                missed_total_next = (missed_wide > WW'(COUNT_MAX)) ?
                                    COUNT_MAX : missed_wide[CW-1:0];
            end
        end
        if (take) begin
            frame_total_next = sat_inc(frame_total_reg);
            real_sum_next    = real_wide[SW] ? SUM_MAX : real_wide[SW-1:0];
            sim_sum_next     = sim_wide[SW] ? SUM_MAX : sim_wide[SW-1:0];
            if (head.dilated) begin
                dilated_total_next = sat_inc(dilated_total_reg);
            end
            if (head.spike) begin
                spike_total_next = sat_inc(spike_total_reg);
            end
            if (head.raw_us > worst_us_reg) begin
                worst_us_next   = head.raw_us;
                worst_time_next = head.elapsed_ms;
            end
        end
    end

    assign rel_index = head.stat_index - 5'(fthm_pkg::NUM_BUCKETS);

    always_comb begin
        rd_value = '0;
        if (32'(head.stat_index) < fthm_pkg::NUM_BUCKETS) begin
            rd_value = SW'(bucket_reg[head.stat_index[fthm_pkg::SLOT_WIDTH-1:0]]);
        end else begin
            unique case (rel_index)
                fthm_pkg::STAT_FRAMES:     rd_value = SW'(frame_total_reg);
                fthm_pkg::STAT_DILATED:    rd_value = SW'(dilated_total_reg);
                fthm_pkg::STAT_SPIKES:     rd_value = SW'(spike_total_reg);
                fthm_pkg::STAT_MISSED:     rd_value = SW'(missed_total_reg);
                fthm_pkg::STAT_REAL_SUM:   rd_value = real_sum_reg;
                fthm_pkg::STAT_SIM_SUM:    rd_value = sim_sum_reg;
                fthm_pkg::STAT_WORST:      rd_value = SW'(worst_us_reg);
                fthm_pkg::STAT_WORST_TIME: rd_value = SW'(worst_time_reg);
                default:                   rd_value = '0;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (!m_valid_reg || m_tready) begin
            m_valid_next = pop && is_read;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_frame_reg    <= '0;
            frame_total_reg   <= '0;
            dilated_total_reg <= '0;
            spike_total_reg   <= '0;
            missed_total_reg  <= '0;
            real_sum_reg      <= '0;
            sim_sum_reg       <= '0;
            worst_us_reg      <= '0;
            worst_time_reg    <= '0;
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < fthm_pkg::NUM_BUCKETS; i++) begin
                bucket_reg[i] <= '0;
            end
        end else begin
            prev_frame_reg    <= prev_frame_next;
            frame_total_reg   <= frame_total_next;
            dilated_total_reg <= dilated_total_next;
            spike_total_reg   <= spike_total_next;
            missed_total_reg  <= missed_total_next;
            real_sum_reg      <= real_sum_next;
            sim_sum_reg       <= sim_sum_next;
            worst_us_reg      <= worst_us_next;
            worst_time_reg    <= worst_time_next;
            m_valid_reg       <= m_valid_next;
            for (int i = 0; i < fthm_pkg::NUM_BUCKETS; i++) begin
                bucket_reg[i] <= bucket_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && is_read) begin
            m_value_reg <= rd_value;
            m_which_reg <= head.stat_index;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, m_which_reg, m_value_reg};

    a_worst_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> worst_us_reg >= $past(worst_us_reg))
        else $error("worst frame time decreased");

    a_missed_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> missed_total_reg >= $past(missed_total_reg))
        else $error("missed count decreased");

    a_prev_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !sample_new |=> $stable(prev_frame_reg))
        else $error("frame counter moved without a new sample");

    a_frame_needs_new_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(frame_total_reg) |-> !$stable(prev_frame_reg))
        else $error("frame counted without a new counter value");

endmodule

// File: rtl/frame_time_histogram_monitor_unit.sv
// ----------------------------------------------------------------------------
// Frame time histogram monitor
// Sorts frame samples into a fixed-edge histogram with saturating totals and
// returns one statistic per read request.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless the queue is full. Each request is
// classified as it is accepted and written into a two-entry queue; the
// statistics engine retires one per cycle, but a read waits while the output
// register holds an untaken result. A read result goes from the queue to the
// output register on m_tdata; samples produce no output. With m_tready low a
// finished result waits in the output register while the queue still takes
// up to two more requests; s_tready drops only when the queue is full.
// Configuration writes are registered and take effect on later requests.
module frame_time_histogram_monitor_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [fthm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // frame_number, raw_us, step_us, elapsed_ms, stat_index
    input  logic [fthm_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // stat_value, stat_which
    output logic [fthm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    fthm_pkg::entry_t front_entry;
    fthm_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             empty;
    logic             full;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    fthm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .entry     (front_entry)
    );

    fthm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    fthm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
